FILE: hdl/ptl_pkg.sv
// ----------------------------------------------------------------------------
// Pedestrian traffic light package
// Phase codes, configuration register indexes, widths and reset durations
// shared by the sequencer.
// ----------------------------------------------------------------------------
package ptl_pkg;

    // Width of one duration register and of the phase tick counter.
    localparam int DUR_W   = 10;
    // Width of the configuration register index.
    localparam int CFG_A_W = 3;
    // Number of duration registers.
    localparam int NUM_DUR = 6;

    // Phase of the sequence; the encoding is the phase code on the output.
    typedef enum logic [2:0] {
        PH_TEST     = 3'd0,
        PH_RED_WAIT = 3'd1,
        PH_RED_HOLD = 3'd2,
        PH_GREEN    = 3'd3,
        PH_SLOW     = 3'd4,
        PH_FAST     = 3'd5,
        PH_YELLOW   = 3'd6,
        PH_HALT     = 3'd7
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_A_W-1:0] {
        REG_LAMP_TEST  = 3'd0,
        REG_RED_HOLD   = 3'd1,
        REG_GREEN      = 3'd2,
        REG_SLOW_BLINK = 3'd3,
        REG_FAST_BLINK = 3'd4,
        REG_YELLOW     = 3'd5
    } cfg_reg_t;

    // Durations after reset, in ticks.
    localparam logic [DUR_W-1:0] LAMP_TEST_RST  = 10'd4;
    localparam logic [DUR_W-1:0] RED_HOLD_RST   = 10'd8;
    localparam logic [DUR_W-1:0] GREEN_RST      = 10'd20;
    localparam logic [DUR_W-1:0] SLOW_BLINK_RST = 10'd20;
    localparam logic [DUR_W-1:0] FAST_BLINK_RST = 10'd20;
    localparam logic [DUR_W-1:0] YELLOW_RST     = 10'd8;

endpackage

FILE: hdl/pedestrian_traffic_light_sequencer.sv
// ----------------------------------------------------------------------------
// Pedestrian traffic light sequencer
// Steps a crossing light through lamp test, red wait, red hold, green, slow
// and fast green blink, and yellow, one tick word at a time, with a stop
// request that parks the light dark until reset.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                    Handshake
//  -------   --------------------------------------   -------------------
//  tick in   s_button_level, s_stop_request           s_valid / s_ready
//  result    m_red_lamp, m_yellow_lamp, m_green_lamp,  m_valid / m_ready
//            m_buzzer_enable, m_phase_code
//  config    cfg_addr, cfg_wdata                      cfg_wr_en (no wait)
//
//  Each tick word is handled on acceptance: the phase and tick counters update
//  and the result word lands in the output register, so one word per cycle is
//  sustained while m_ready is high.
//  A new word is taken whenever the output register is empty or being read.
//  Reset restores the phase to lamp test and all durations to their defaults.
//
module pedestrian_traffic_light_sequencer #(
    parameter int TICKS_PER_SECOND = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Tick input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_button_level,
    input  logic                         s_stop_request,
    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_red_lamp,
    output logic                         m_yellow_lamp,
    output logic                         m_green_lamp,
    output logic                         m_buzzer_enable,
    output logic [2:0]                   m_phase_code,
    // Configuration write port
    input  logic                         cfg_wr_en,
    input  logic [ptl_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [ptl_pkg::DUR_W-1:0]    cfg_wdata
);

    import ptl_pkg::*;

    // Blink periods in ticks and the widths of their position counters.
    localparam int SLOW_PERIOD = TICKS_PER_SECOND;
    localparam int FAST_PERIOD = TICKS_PER_SECOND / 2;
    localparam int SLOW_W      = $clog2(SLOW_PERIOD);
    localparam int FAST_W      = (FAST_PERIOD > 2) ? $clog2(FAST_PERIOD) : 1;
    localparam logic [SLOW_W-1:0] SLOW_LAST = SLOW_W'(SLOW_PERIOD - 1);
    localparam logic [SLOW_W-1:0] SLOW_HALF = SLOW_W'(SLOW_PERIOD / 2);
    localparam logic [FAST_W-1:0] FAST_LAST = FAST_W'(FAST_PERIOD - 1);
    localparam logic [FAST_W-1:0] FAST_HALF = FAST_W'(FAST_PERIOD / 2);

    // Duration registers.
    logic [DUR_W-1:0]  lamp_test_reg;
    logic [DUR_W-1:0]  red_hold_reg;
    logic [DUR_W-1:0]  green_reg;
    logic [DUR_W-1:0]  slow_blink_reg;
    logic [DUR_W-1:0]  fast_blink_reg;
    logic [DUR_W-1:0]  yellow_reg;

    // Sequencer state. The blink counters track the tick counter modulo
    // each blink period.
    phase_t            phase_reg, phase_next;
    logic [DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic [SLOW_W-1:0] slow_cnt_reg, slow_cnt_next;
    logic [FAST_W-1:0] fast_cnt_reg, fast_cnt_next;

    // Output register.
    logic              m_valid_reg;
    logic              red_reg, yellow_reg_out, green_lamp_reg, buzz_reg;
    logic [2:0]        code_reg;

    // Combinational result of the current tick.
    phase_t            shown;
    logic              red_c, yellow_c, green_c, buzz_c;
    logic [DUR_W-1:0]  duration;
    logic [DUR_W:0]    elapsed_inc;
    logic              s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Configuration writes; indexes past the last register are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_test_reg  <= LAMP_TEST_RST;
            red_hold_reg   <= RED_HOLD_RST;
            green_reg      <= GREEN_RST;
            slow_blink_reg <= SLOW_BLINK_RST;
            fast_blink_reg <= FAST_BLINK_RST;
            yellow_reg     <= YELLOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LAMP_TEST:  lamp_test_reg  <= cfg_wdata;
                REG_RED_HOLD:   red_hold_reg   <= cfg_wdata;
                REG_GREEN:      green_reg      <= cfg_wdata;
                REG_SLOW_BLINK: slow_blink_reg <= cfg_wdata;
                REG_FAST_BLINK: fast_blink_reg <= cfg_wdata;
                REG_YELLOW:     yellow_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The phase in force for this tick; a stop request overrides it at once.
    assign shown = s_stop_request ? PH_HALT : phase_reg;

    // Duration of the current timed phase. A zero duration ends the phase
    // after one tick, the same as one, because elapsed plus one is never zero.
    always_comb begin
        unique case (shown)
            PH_TEST:     duration = lamp_test_reg;
            PH_RED_HOLD: duration = red_hold_reg;
            PH_GREEN:    duration = green_reg;
            PH_SLOW:     duration = slow_blink_reg;
            PH_FAST:     duration = fast_blink_reg;
            default:     duration = yellow_reg;
        endcase
    end

    assign elapsed_inc = {1'b0, elapsed_reg} + (DUR_W+1)'(1);

    // Next phase and tick counters.
    always_comb begin
        phase_next    = shown;
        elapsed_next  = '0;
        slow_cnt_next = '0;
        fast_cnt_next = '0;
        unique case (shown)
            PH_RED_WAIT: begin
                if (s_button_level) begin
                    phase_next = PH_RED_HOLD;
                end
            end
            PH_HALT: ;
            default: begin
                if (elapsed_inc >= {1'b0, duration}) begin
                    phase_next = (shown == PH_YELLOW) ? PH_RED_WAIT
                                                      : phase_t'(shown + 3'd1);
                end else begin
                    elapsed_next  = elapsed_inc[DUR_W-1:0];
                    slow_cnt_next = (slow_cnt_reg == SLOW_LAST) ? '0
                                  : slow_cnt_reg + SLOW_W'(1);
                    fast_cnt_next = (fast_cnt_reg == FAST_LAST) ? '0
                                  : fast_cnt_reg + FAST_W'(1);
                end
            end
        endcase
    end

    // Lamp and buzzer drive for the phase shown this tick.
    always_comb begin
        red_c    = 1'b0;
        yellow_c = 1'b0;
        green_c  = 1'b0;
        buzz_c   = 1'b0;
        unique case (shown)
            PH_TEST: begin
                red_c    = 1'b1;
                yellow_c = 1'b1;
                green_c  = 1'b1;
                buzz_c   = 1'b1;
            end
            PH_RED_WAIT, PH_RED_HOLD: begin
                red_c = 1'b1;
            end
            PH_GREEN: begin
                green_c = 1'b1;
            end
            PH_SLOW: begin
                green_c = slow_cnt_reg < SLOW_HALF;
                buzz_c  = slow_cnt_reg < SLOW_HALF;
            end
            PH_FAST: begin
                green_c = fast_cnt_reg < FAST_HALF;
                buzz_c  = fast_cnt_reg < FAST_HALF;
            end
            PH_YELLOW: begin
                yellow_c = 1'b1;
                buzz_c   = 1'b1;
            end
            default: ;
        endcase
    end

    // State registers advance once per accepted tick word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TEST;
            elapsed_reg  <= '0;
            slow_cnt_reg <= '0;
            fast_cnt_reg <= '0;
        end else if (s_fire) begin
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            slow_cnt_reg <= slow_cnt_next;
            fast_cnt_reg <= fast_cnt_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with each accepted word.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            red_reg        <= red_c;
            yellow_reg_out <= yellow_c;
            green_lamp_reg <= green_c;
            buzz_reg       <= buzz_c;
            code_reg       <= 3'(shown);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_lamp      = red_reg;
    assign m_yellow_lamp   = yellow_reg_out;
    assign m_green_lamp    = green_lamp_reg;
    assign m_buzzer_enable = buzz_reg;
    assign m_phase_code    = code_reg;

    // Once halted, the sequencer stays halted until reset.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("halted phase was left without reset");

    // An accepted stop request halts the sequencer.
    a_stop_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_stop_request |=> phase_reg == PH_HALT)
        else $error("stop request did not halt the sequencer");

    // Red wait never accumulates ticks.
    a_wait_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_RED_WAIT |-> elapsed_reg == '0)
        else $error("tick counter running during red wait");

    // A halted result word drives every lamp and the buzzer off.
    a_halt_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase_code == 3'(PH_HALT) |->
            !m_red_lamp && !m_yellow_lamp && !m_green_lamp && !m_buzzer_enable)
        else $error("lamps lit in halted result word");

endmodule
